### src/bvam_pkg.sv
// ----------------------------------------------------------------------------
// bvam_pkg
// Shared widths, opcodes and helpers for the bit-vector approximate matcher.
// ----------------------------------------------------------------------------
package bvam_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int ALPHABET    = 128;

    localparam int VEC_W   = 64;
    localparam int BIT_W   = $clog2(VEC_W);
    localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
    localparam int SYM_W   = 7;
    localparam int ADDR_W  = $clog2(ALPHABET);
    localparam int OP_W    = 2;
    localparam int SCORE_W = 7;
    localparam int POS_W   = 32;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_TEXT   = 2'd2;

    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

    // Vector with the lowest n bits set, saturating at the full width.
    function automatic logic [VEC_W-1:0] ones_below(input logic [LEN_W-1:0] n);
        logic [VEC_W-1:0] r;
        if (32'(n) >= VEC_W) begin
            r = '1;
        end else begin
            r = (VEC_W'(1) << n) - VEC_W'(1);
        end
        return r;
    endfunction

endpackage

### src/bvam_in_if.sv
// ----------------------------------------------------------------------------
// bvam_in_if
// Request channel carrying one opcode and symbol per transfer.
// ----------------------------------------------------------------------------
interface bvam_in_if;
    logic                          valid;
    logic                          ready;
    logic [bvam_pkg::OP_W-1:0]     opcode;
    logic [bvam_pkg::SYM_W-1:0]    symbol;

    modport source (output valid, output opcode, output symbol, input ready);
    modport sink   (input valid, input opcode, input symbol, output ready);
endinterface

### src/bvam_out_if.sv
// ----------------------------------------------------------------------------
// bvam_out_if
// Result channel carrying score, match flag and text position.
// ----------------------------------------------------------------------------
interface bvam_out_if;
    logic                          valid;
    logic                          ready;
    logic [bvam_pkg::SCORE_W-1:0]  score;
    logic                          is_match;
    logic [bvam_pkg::POS_W-1:0]    position;

    modport source (output valid, output score, output is_match, output position,
                    input ready);
    modport sink   (input valid, input score, input is_match, input position,
                    output ready);
endinterface

### src/bvam_ram.sv
// ----------------------------------------------------------------------------
// bvam_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bvam_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/bit_vector_approx_match.sv
// Pipeline: a text request's mask is read at acceptance into stage one, and
// the bit-vector update then fills the output register once it is free.
// Throughput: one request per cycle while results are taken (a text request
// waits in stage one on a held output); recurrence and mask read allow it.
// Reset (synchronous, active low) empties the pattern, clears all mask
// valid bits and the search state; the mask memory itself is not cleared.
// ----------------------------------------------------------------------------
// bit_vector_approx_match
// Approximate text search with the bit-vector edit-distance recurrence.
// ----------------------------------------------------------------------------
module bit_vector_approx_match (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bvam_pkg::SCORE_W-1:0] i_cfg_wdata,
    bvam_in_if.sink                      i_item,
    bvam_out_if.source                   o_result
);

    // Handshake
    logic in_acc;
    logic out_free;
    logic s1_fire;

    // Stage one (memory data available)
    logic                          r_s1_valid;
    logic [bvam_pkg::OP_W-1:0]     r_s1_op;
    logic [bvam_pkg::SYM_W-1:0]    r_s1_sym;
    logic                          r_fwd_hit;
    logic [bvam_pkg::VEC_W-1:0]    r_fwd_data;

    // Search state
    logic [bvam_pkg::ALPHABET-1:0] r_mask_vld;
    logic [bvam_pkg::LEN_W-1:0]    r_len;
    logic [bvam_pkg::VEC_W-1:0]    r_pv;
    logic [bvam_pkg::VEC_W-1:0]    r_mv;
    logic [bvam_pkg::SCORE_W-1:0]  r_score;
    logic [bvam_pkg::POS_W-1:0]    r_idx;
    logic [bvam_pkg::SCORE_W-1:0]  r_thr;

    logic [bvam_pkg::ALPHABET-1:0] n_mask_vld;
    logic [bvam_pkg::LEN_W-1:0]    n_len;
    logic [bvam_pkg::VEC_W-1:0]    n_pv;
    logic [bvam_pkg::VEC_W-1:0]    n_mv;
    logic [bvam_pkg::SCORE_W-1:0]  n_score;
    logic [bvam_pkg::POS_W-1:0]    n_idx;

    // Output register
    logic                          r_out_valid;
    logic [bvam_pkg::SCORE_W-1:0]  r_out_score;
    logic                          r_out_match;
    logic [bvam_pkg::POS_W-1:0]    r_out_pos;

    // Memory port
    logic                          ram_we;
    logic [bvam_pkg::ADDR_W-1:0]   ram_waddr;
    logic [bvam_pkg::VEC_W-1:0]    ram_wdata;
    logic [bvam_pkg::VEC_W-1:0]    ram_q;

    // Datapath
    logic                          sym_ok;
    logic [bvam_pkg::ADDR_W-1:0]   s1_addr;
    logic [bvam_pkg::VEC_W-1:0]    stored;
    logic [bvam_pkg::VEC_W-1:0]    eq;
    logic                          full;
    logic [bvam_pkg::BIT_W-1:0]    top_bit;
    logic [bvam_pkg::VEC_W-1:0]    xv;
    logic [bvam_pkg::VEC_W-1:0]    xh;
    logic [bvam_pkg::VEC_W-1:0]    ph;
    logic [bvam_pkg::VEC_W-1:0]    mh;
    logic [bvam_pkg::SCORE_W-1:0]  score_up;
    logic [bvam_pkg::LEN_W-1:0]    len_inc;

    assign in_acc         = i_item.valid && i_item.ready;
    assign out_free       = !r_out_valid || o_result.ready;
    assign s1_fire        = r_s1_valid && ((r_s1_op != bvam_pkg::OP_TEXT) || out_free);
    assign i_item.ready   = !r_s1_valid || s1_fire;

    bvam_ram #(
        .WIDTH (bvam_pkg::VEC_W),
        .DEPTH (bvam_pkg::ALPHABET)
    ) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (i_item.symbol[bvam_pkg::ADDR_W-1:0]),
        .o_rdata (ram_q)
    );

    assign sym_ok  = 32'(r_s1_sym) < bvam_pkg::ALPHABET;
    assign s1_addr = r_s1_sym[bvam_pkg::ADDR_W-1:0];
    // A write in the cycle of the read is not seen by the memory output.
    assign stored  = r_fwd_hit ? r_fwd_data : ram_q;
    assign eq      = (sym_ok && r_mask_vld[s1_addr]) ? stored : '0;
    assign full    = 32'(r_len) >= bvam_pkg::MAX_PATTERN;
    assign len_inc = r_len + bvam_pkg::LEN_W'(1);

    assign ram_we    = s1_fire && (r_s1_op == bvam_pkg::OP_APPEND) && !full && sym_ok;
    assign ram_waddr = s1_addr;
    assign ram_wdata = eq | (bvam_pkg::VEC_W'(1) << r_len[bvam_pkg::BIT_W-1:0]);

    assign top_bit = r_len[bvam_pkg::BIT_W-1:0] - bvam_pkg::BIT_W'(1);
    assign xv      = eq | r_mv;
    assign xh      = (((eq & r_pv) + r_pv) ^ r_pv) | eq;
    assign ph      = r_mv | ~(xh | r_pv);
    assign mh      = r_pv & xh;

    always_comb begin
        score_up = r_score;
        if (ph[top_bit] && (r_score < bvam_pkg::SCORE_MAX)) begin
            score_up = r_score + bvam_pkg::SCORE_W'(1);
        end
    end

    always_comb begin
        n_mask_vld = r_mask_vld;
        n_len      = r_len;
        n_pv       = r_pv;
        n_mv       = r_mv;
        n_score    = r_score;
        n_idx      = r_idx;
        if (s1_fire) begin
            unique case (r_s1_op)
                bvam_pkg::OP_CLEAR: begin
                    n_mask_vld = '0;
                    n_len      = '0;
                    n_pv       = '0;
                    n_mv       = '0;
                    n_score    = '0;
                    n_idx      = '0;
                end
                bvam_pkg::OP_APPEND: begin
                    if (!full) begin
                        if (sym_ok) begin
                            n_mask_vld[s1_addr] = 1'b1;
                        end
                        n_len   = len_inc;
                        n_pv    = bvam_pkg::ones_below(len_inc);
                        n_mv    = '0;
                        n_score = bvam_pkg::SCORE_W'(len_inc);
                        n_idx   = '0;
                    end
                end
                bvam_pkg::OP_TEXT: begin
                    n_idx = r_idx + bvam_pkg::POS_W'(1);
                    if (r_len == '0) begin
                        n_score = '0;
                    end else begin
                        n_score = score_up;
                        if (mh[top_bit] && (score_up != '0)) begin
                            n_score = score_up - bvam_pkg::SCORE_W'(1);
                        end
                        n_pv = (mh << 1) | ~(xv | (ph << 1));
                        n_mv = (ph << 1) & xv;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_mask_vld  <= '0;
            r_len       <= '0;
            r_pv        <= '0;
            r_mv        <= '0;
            r_score     <= '0;
            r_idx       <= '0;
            r_thr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_s1_valid <= i_item.valid;
            end
            if (in_acc) begin
                r_fwd_hit <= ram_we && (ram_waddr == i_item.symbol[bvam_pkg::ADDR_W-1:0]);
            end
            r_mask_vld <= n_mask_vld;
            r_len      <= n_len;
            r_pv       <= n_pv;
            r_mv       <= n_mv;
            r_score    <= n_score;
            r_idx      <= n_idx;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (s1_fire && (r_s1_op == bvam_pkg::OP_TEXT)) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op    <= i_item.opcode;
            r_s1_sym   <= i_item.symbol;
            r_fwd_data <= ram_wdata;
        end
        if (s1_fire && (r_s1_op == bvam_pkg::OP_TEXT)) begin
            r_out_score <= n_score;
            r_out_match <= n_score <= r_thr;
            r_out_pos   <= r_idx;
        end
    end

    assign o_result.valid    = r_out_valid;
    assign o_result.score    = r_out_score;
    assign o_result.is_match = r_out_match;
    assign o_result.position = r_out_pos;

endmodule

### src/bvam_checker.sv
// ----------------------------------------------------------------------------
// bvam_checker
// Port-level checks on the approximate matcher, bound to the top level.
// ----------------------------------------------------------------------------
module bvam_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_cfg_we,
    input logic [bvam_pkg::SCORE_W-1:0] i_cfg_wdata,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [bvam_pkg::SCORE_W-1:0] i_out_score,
    input logic                         i_out_is_match
);

    logic [bvam_pkg::SCORE_W-1:0] r_thr;

    // Shadow copy of the threshold register as written through the port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before it was taken");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result presented straight after reset");

    a_match_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_is_match == (i_out_score <= r_thr)))
        else $error("match flag disagrees with score and threshold");

    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (32'(i_out_score) <= bvam_pkg::MAX_PATTERN))
        else $error("score exceeds the longest pattern");

endmodule

bind bit_vector_approx_match bvam_checker u_bvam_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_cfg_we       (i_cfg_we),
    .i_cfg_wdata    (i_cfg_wdata),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_out_score    (o_result.score),
    .i_out_is_match (o_result.is_match)
);
